// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define CLI_AP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define CLI_AP_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/cli_pkg.sv =====
`default_nettype none

package cli_pkg;

    // Result field widths
    localparam int XW  = 24;
    localparam int YW  = 25;
    // Output tdata: first_x, first_y, second_x, second_y, padded to bytes
    localparam int ODW = ((2 * XW + 2 * YW + 7) / 8) * 8;

    // Result kind
    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_TANGENT = 2'd1,
        ST_TWO     = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== src/circle_line_intersection.sv =====
`default_nettype none
// Circle / line intersection, fully pipelined.
// Pipeline depth is set by the one-bit-per-stage square root (QW stages) and the
// two parallel restoring dividers (KW stages).
// Throughput: one query per cycle; stalls hold each stage, bubbles are squeezed out.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits.
module circle_line_intersection #(
    parameter int COORD_BITS      = 12,
    parameter int FRACTION_DIGITS = 3
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // center_x, center_y, radius, slope, intercept (low to high), zero padded
    input  wire  [((5*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    // first_x, first_y, second_x, second_y (low to high), zero padded
    output logic [cli_pkg::ODW-1:0]      o_m_tdata,
    // status
    output logic [1:0]                   o_m_tuser,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready
);

    localparam int C    = COORD_BITS;
    localparam int S    = 10 ** FRACTION_DIGITS;
    localparam int S2   = S * S;
    localparam logic signed [11:0] SC  = 12'(S);
    localparam logic        [19:0] S2C = 20'(S2);
    localparam int XW   = cli_pkg::XW;
    localparam int YW   = cli_pkg::YW;

    localparam int AW   = 2 * C;          // a = 1 + slope^2
    localparam int HW   = 2 * C + 2;      // h
    localparam int DW   = 2 * C + 2;      // d
    localparam int SHW  = HW + 11;        // S * h
    localparam int EW   = 4 * C + 2;      // E, signed
    localparam int EU   = EW - 1;         // E magnitude
    localparam int LB   = EU / 2;
    localparam int HB   = EU - LB;
    localparam int PLW  = LB + 20;
    localparam int PHW  = HB + 20;
    localparam int TW   = EU + 20;        // S^2 * E
    localparam int QW   = (TW + 1) / 2;   // root bits
    localparam int OPW  = 2 * QW + 1;
    localparam int KW0  = 2 * C + 13;
    localparam int KW   = (KW0 > QW + 2) ? KW0 : QW + 2;  // numerators, signed
    localparam int NQ   = KW;             // quotient bits

    localparam int ST_SQ0  = 5;
    localparam int ST_PREP = ST_SQ0 + QW + 1;
    localparam int ST_FIX  = ST_PREP + NQ + 1;
    localparam int N       = ST_FIX + 1;

    typedef struct packed {
        logic                  bad;
        logic                  neg;
        logic                  zero;
        logic [AW-1:0]         a;
        logic signed [C-1:0]   sl;
        logic signed [C-1:0]   ic;
        logic signed [SHW-1:0] sh;
    } t_side;

    typedef struct packed {
        logic [NQ-1:0] num_a;
        logic [NQ-1:0] num_b;
        logic [NQ-1:0] quo_a;
        logic [NQ-1:0] quo_b;
        logic [AW:0]   rem_a;
        logic [AW:0]   rem_b;
        logic          neg_a;
        logic          neg_b;
        logic          exact;
    } t_div;

    // ---------------- flow control ----------------
    logic [1:N]   r_vld;
    logic [1:N+1] w_adv;
    logic [1:N]   w_vin;

    assign w_adv[N+1] = i_m_tready;
    assign w_vin[1]   = i_s_tvalid;

    for (genvar k = 1; k <= N; k++) begin : g_flow
        // a stage moves when the output drains or any stage at or after it is empty
        assign w_adv[k] = i_m_tready | ~(&r_vld[k:N]);
        if (k > 1) begin : g_vin
            assign w_vin[k] = r_vld[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end
    end

    assign o_s_tready = w_adv[1];
    assign o_m_tvalid = r_vld[N];

    // ---------------- stage 1: coefficients ----------------
    logic signed [C-1:0]   w_x0, w_y0, w_r, w_sl, w_ic;
    logic signed [2*C-1:0] w_sl2, w_rr;
    logic signed [C:0]     w_dif;
    logic signed [HW-1:0]  n_s1_h;
    logic signed [DW-1:0]  n_s1_d;

    assign w_x0  = $signed(i_s_tdata[C-1:0]);
    assign w_y0  = $signed(i_s_tdata[2*C-1:C]);
    assign w_r   = $signed(i_s_tdata[3*C-1:2*C]);
    assign w_sl  = $signed(i_s_tdata[4*C-1:3*C]);
    assign w_ic  = $signed(i_s_tdata[5*C-1:4*C]);
    assign w_sl2 = (2*C)'(w_sl) * (2*C)'(w_sl);
    assign w_rr  = (2*C)'(w_r) * (2*C)'(w_r);
    assign w_dif = (C+1)'(w_ic) - (C+1)'(w_y0);
    assign n_s1_h = HW'(w_sl) * HW'(w_dif) - HW'(w_x0);
    assign n_s1_d = DW'(w_sl) * DW'(w_x0) - DW'(w_y0) + DW'(w_ic);

    logic [2*C-1:0]       r_s1_rr;
    logic signed [HW-1:0] r_s1_h;
    logic signed [DW-1:0] r_s1_d;
    t_side                r_s1_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_rr        <= $unsigned(w_rr);
            r_s1_h         <= n_s1_h;
            r_s1_d         <= n_s1_d;
            r_s1_side.bad  <= w_r[C-1] || (w_r == '0);
            r_s1_side.neg  <= 1'b0;
            r_s1_side.zero <= 1'b0;
            r_s1_side.a    <= AW'($unsigned(w_sl2)) + AW'(1);
            r_s1_side.sl   <= w_sl;
            r_s1_side.ic   <= w_ic;
            r_s1_side.sh   <= '0;
        end
    end

    // ---------------- stage 2: a*r^2, d^2, S*h ----------------
    logic [4*C-1:0]        n_s2_ar2;
    logic signed [2*DW-1:0] n_s2_dd;
    logic signed [SHW-1:0] n_s2_sh;
    t_side                 n_s2_side;

    assign n_s2_ar2 = (4*C)'(r_s1_side.a) * (4*C)'(r_s1_rr);
    assign n_s2_dd  = (2*DW)'(r_s1_d) * (2*DW)'(r_s1_d);
    assign n_s2_sh  = SHW'(r_s1_h) * SHW'(SC);

    always_comb begin
        n_s2_side    = r_s1_side;
        n_s2_side.sh = n_s2_sh;
    end

    logic [4*C-1:0]  r_s2_ar2;
    logic [2*DW-1:0] r_s2_dd;
    t_side           r_s2_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s2_ar2  <= n_s2_ar2;
            r_s2_dd   <= $unsigned(n_s2_dd);
            r_s2_side <= n_s2_side;
        end
    end

    // ---------------- stage 3: discriminant ----------------
    logic signed [EW-1:0] n_s3_e;
    t_side                n_s3_side;
    assign n_s3_e = $signed(EW'(r_s2_ar2) - EW'(r_s2_dd));

    always_comb begin
        n_s3_side      = r_s2_side;
        n_s3_side.neg  = n_s3_e[EW-1];
        n_s3_side.zero = (n_s3_e == '0);
    end

    logic [EU-1:0] r_s3_eu;
    t_side         r_s3_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s3_eu   <= n_s3_e[EW-1] ? '0 : n_s3_e[EU-1:0];
            r_s3_side <= n_s3_side;
        end
    end

    // ---------------- stage 4: S^2 * E, split product ----------------
    logic [PLW-1:0] r_s4_pl;
    logic [PHW-1:0] r_s4_ph;
    t_side          r_s4_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s4_pl   <= PLW'(S2C) * PLW'(r_s3_eu[LB-1:0]);
            r_s4_ph   <= PHW'(S2C) * PHW'(r_s3_eu[EU-1:LB]);
            r_s4_side <= r_s3_side;
        end
    end

    // ---------------- stage 5 and square root pipeline ----------------
    logic [TW-1:0]  n_s5_t;
    logic [OPW-1:0] r_op  [0:QW];
    logic [OPW-1:0] r_res [0:QW];
    t_side          r_sqs [0:QW];

    assign n_s5_t = (TW'(r_s4_ph) << LB) + TW'(r_s4_pl);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SQ0]) begin
            r_op[0]  <= OPW'(n_s5_t);
            r_res[0] <= '0;
            r_sqs[0] <= r_s4_side;
        end
    end

    // one root bit per stage
    for (genvar j = 1; j <= QW; j++) begin : g_sqrt
        localparam logic [OPW-1:0] ONE = OPW'(1) << (2 * (QW - j));
        logic [OPW-1:0] w_try;
        logic           w_take;
        assign w_try  = r_res[j-1] + ONE;
        assign w_take = (r_op[j-1] >= w_try);
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_SQ0+j]) begin
                r_op[j]  <= w_take ? r_op[j-1] - w_try : r_op[j-1];
                r_res[j] <= w_take ? (r_res[j-1] >> 1) + ONE : r_res[j-1] >> 1;
                r_sqs[j] <= r_sqs[j-1];
            end
        end
    end

    // ---------------- numerator preparation ----------------
    logic signed [KW-1:0] w_q, w_sh, w_ka, w_kb;
    t_div                 n_prep;

    assign w_q  = $signed(KW'(r_res[QW][QW-1:0]));
    assign w_sh = KW'(r_sqs[QW].sh);
    assign w_ka = w_q + w_sh;
    assign w_kb = w_q - w_sh;

    always_comb begin
        n_prep       = '0;
        n_prep.neg_a = w_ka[KW-1];
        n_prep.neg_b = w_kb[KW-1];
        n_prep.num_a = w_ka[KW-1] ? $unsigned(-w_ka) : $unsigned(w_ka);
        n_prep.num_b = w_kb[KW-1] ? $unsigned(-w_kb) : $unsigned(w_kb);
        n_prep.exact = (r_op[QW] == '0);
    end

    t_div  r_dv  [0:NQ];
    t_side r_dvs [0:NQ];

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PREP]) begin
            r_dv[0]  <= n_prep;
            r_dvs[0] <= r_sqs[QW];
        end
    end

    // ---------------- dividers: one quotient bit per stage ----------------
    for (genvar i = 1; i <= NQ; i++) begin : g_div
        localparam int B = NQ - i;
        logic [AW:0] w_ra, w_rb, w_den;
        logic        w_ta, w_tb;
        t_div        n_dv;
        assign w_den = {1'b0, r_dvs[i-1].a};
        assign w_ra  = {r_dv[i-1].rem_a[AW-1:0], r_dv[i-1].num_a[B]};
        assign w_rb  = {r_dv[i-1].rem_b[AW-1:0], r_dv[i-1].num_b[B]};
        assign w_ta  = (w_ra >= w_den);
        assign w_tb  = (w_rb >= w_den);
        always_comb begin
            n_dv          = r_dv[i-1];
            n_dv.rem_a    = w_ta ? w_ra - w_den : w_ra;
            n_dv.rem_b    = w_tb ? w_rb - w_den : w_rb;
            n_dv.quo_a[B] = w_ta;
            n_dv.quo_b[B] = w_tb;
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_PREP+i]) begin
                r_dv[i]  <= n_dv;
                r_dvs[i] <= r_dvs[i-1];
            end
        end
    end

    // ---------------- truncation fix-up ----------------
    // negative numerator with a fractional root: -ceil(|k|/a) + 1
    logic signed [KW:0] w_qa, w_qb, w_fa, w_fb;
    logic signed [KW:0] w_ca, w_cb;

    assign w_qa = $signed({1'b0, r_dv[NQ].quo_a});
    assign w_qb = $signed({1'b0, r_dv[NQ].quo_b});
    assign w_ca = $signed((KW+1)'(r_dv[NQ].rem_a != '0));
    assign w_cb = $signed((KW+1)'(r_dv[NQ].rem_b != '0));

    always_comb begin
        if (!r_dv[NQ].neg_a) begin
            w_fa = w_qa;
        end else if (r_dv[NQ].exact) begin
            w_fa = -w_qa;
        end else begin
            w_fa = -w_qa - w_ca + (KW+1)'(1);
        end
        if (!r_dv[NQ].neg_b) begin
            w_fb = w_qb;
        end else if (r_dv[NQ].exact) begin
            w_fb = -w_qb;
        end else begin
            w_fb = -w_qb - w_cb + (KW+1)'(1);
        end
    end

    logic signed [KW:0] r_fx_xa, r_fx_xb;
    t_side              r_fx_side;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_FIX]) begin
            r_fx_xa   <= -w_fa;
            r_fx_xb   <= w_fb;
            r_fx_side <= r_dvs[NQ];
        end
    end

    // ---------------- output stage: y values, status ----------------
    logic signed [YW-1:0] w_xa_t, w_xb_t, w_off, n_ya, n_yb;
    cli_pkg::t_status     n_status;
    logic                 w_none;

    assign w_xa_t = YW'(r_fx_xa);
    assign w_xb_t = YW'(r_fx_xb);
    assign w_off  = YW'(SC) * YW'(r_fx_side.ic);
    assign n_ya   = YW'(r_fx_side.sl) * w_xa_t + w_off;
    assign n_yb   = YW'(r_fx_side.sl) * w_xb_t + w_off;
    assign w_none = r_fx_side.bad || r_fx_side.neg;

    always_comb begin
        if (r_fx_side.bad) begin
            n_status = cli_pkg::ST_BAD;
        end else if (r_fx_side.neg) begin
            n_status = cli_pkg::ST_NONE;
        end else if (r_fx_side.zero) begin
            n_status = cli_pkg::ST_TANGENT;
        end else begin
            n_status = cli_pkg::ST_TWO;
        end
    end

    cli_pkg::t_status     r_o_status;
    logic signed [XW-1:0] r_o_x1, r_o_x2;
    logic signed [YW-1:0] r_o_y1, r_o_y2;

    always_ff @(posedge i_clk) begin
        if (w_adv[N]) begin
            r_o_status <= n_status;
            r_o_x1     <= w_none ? '0 : XW'(r_fx_xa);
            r_o_x2     <= w_none ? '0 : XW'(r_fx_xb);
            r_o_y1     <= w_none ? '0 : n_ya;
            r_o_y2     <= w_none ? '0 : n_yb;
        end
    end

    assign o_m_tuser = r_o_status;
    assign o_m_tdata = {(cli_pkg::ODW - 2*XW - 2*YW)'(0), r_o_y2, r_o_x2, r_o_y1, r_o_x1};

endmodule

`default_nettype wire

// ===== src/cli_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module cli_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_valid,
    input wire                     i_ready,
    input wire [cli_pkg::ODW-1:0]  i_data,
    input wire [1:0]               i_user
);

    // a stalled result holds
    `CLI_AP(a_hold, i_valid && !i_ready |=> i_valid && $stable(i_data) && $stable(i_user), "result changed while stalled")
    // no output after reset
    `CLI_AP_ALWAYS(a_rst, !i_rst_n |=> !i_valid, "valid right after reset")
    // bad radius carries no coordinates
    `CLI_AP(a_bad_zero, i_valid && i_user == cli_pkg::ST_BAD |-> i_data == '0, "bad radius with nonzero data")
    // tangent point is reported twice
    `CLI_AP(a_tangent, i_valid && i_user == cli_pkg::ST_TANGENT |-> i_data[48:0] == i_data[97:49], "tangent points differ")
    // two points come out ordered by x
    `CLI_AP(a_order, i_valid && i_user == cli_pkg::ST_TWO |-> $signed(i_data[23:0]) <= $signed(i_data[72:49]), "points out of order")

endmodule

bind circle_line_intersection cli_checker u_cli_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_m_tvalid),
    .i_ready (i_m_tready),
    .i_data  (o_m_tdata),
    .i_user  (o_m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int CB  = 12;
    localparam int IDW = ((5 * CB + 7) / 8) * 8;
    localparam longint SCALE = 1000;

    typedef struct {
        cli_pkg::t_status          status;
        logic [cli_pkg::XW-1:0]    x1;
        logic [cli_pkg::YW-1:0]    y1;
        logic [cli_pkg::XW-1:0]    x2;
        logic [cli_pkg::YW-1:0]    y2;
    } t_points;

    // Expected intersections, oldest first
    class intersect_sb;
        t_points pending[$];
        int      errors;

        // truncate (k + f) / m toward zero, f in [0,1), f == 0 iff exact
        static function longint trunc_div(longint k, longint m, bit exact);
            if (k >= 0 || exact) return k / m;
            return -((-k + m - 1) / m) + 1;
        endfunction

        static function t_points solve_query(logic [IDW-1:0] d);
            t_points p;
            longint cx, cy, r, sl, ic, a, h, dd, e, q, xa, xb, t;
            logic [127:0] tgt, tt;
            bit exact;
            cx = longint'($signed(d[0*CB +: CB]));
            cy = longint'($signed(d[1*CB +: CB]));
            r  = longint'($signed(d[2*CB +: CB]));
            sl = longint'($signed(d[3*CB +: CB]));
            ic = longint'($signed(d[4*CB +: CB]));
            xa = 0;
            xb = 0;
            p.y1 = '0;
            p.y2 = '0;
            if (r <= 0) begin
                p.status = cli_pkg::ST_BAD;
            end else begin
                a  = 1 + sl * sl;
                h  = sl * (ic - cy) - cx;
                dd = sl * cx - cy + ic;
                e  = a * r * r - dd * dd;
                if (e < 0) begin
                    p.status = cli_pkg::ST_NONE;
                end else begin
                    p.status = (e == 0) ? cli_pkg::ST_TANGENT : cli_pkg::ST_TWO;
                    // S^2*e can pass 2^63; bitwise integer sqrt on a wide target
                    tgt = 128'(SCALE * SCALE) * 128'(e);
                    q = 0;
                    for (int b = 39; b >= 0; b--) begin
                        t  = q | (longint'(1) << b);
                        tt = 128'(t) * 128'(t);
                        if (tt <= tgt) q = t;
                    end
                    tt = 128'(q) * 128'(q);
                    exact = (tt == tgt);
                    xb = trunc_div(-SCALE * h + q, a, exact);
                    xa = -trunc_div(SCALE * h + q, a, exact);
                    p.y1 = cli_pkg::YW'(sl * xa + SCALE * ic);
                    p.y2 = cli_pkg::YW'(sl * xb + SCALE * ic);
                end
            end
            p.x1 = cli_pkg::XW'(xa);
            p.x2 = cli_pkg::XW'(xb);
            return p;
        endfunction

        function void note_query(logic [IDW-1:0] d);
            pending.push_back(solve_query(d));
        endfunction

        function void check_result(logic [cli_pkg::ODW-1:0] d, logic [1:0] st);
            t_points e;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d", st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $error("status exp %0d got %0d", e.status, st); errors++;
            end
            if (d[0 +: cli_pkg::XW] !== e.x1) begin
                $error("first_x exp %0d got %0d", $signed(e.x1),
                       $signed(d[0 +: cli_pkg::XW]));
                errors++;
            end
            if (d[cli_pkg::XW +: cli_pkg::YW] !== e.y1) begin
                $error("first_y exp %0d got %0d", $signed(e.y1),
                       $signed(d[cli_pkg::XW +: cli_pkg::YW]));
                errors++;
            end
            if (d[cli_pkg::XW+cli_pkg::YW +: cli_pkg::XW] !== e.x2) begin
                $error("second_x exp %0d got %0d", $signed(e.x2),
                       $signed(d[cli_pkg::XW+cli_pkg::YW +: cli_pkg::XW]));
                errors++;
            end
            if (d[2*cli_pkg::XW+cli_pkg::YW +: cli_pkg::YW] !== e.y2) begin
                $error("second_y exp %0d got %0d", $signed(e.y2),
                       $signed(d[2*cli_pkg::XW+cli_pkg::YW +: cli_pkg::YW]));
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic [IDW-1:0]          i_s_tdata;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [cli_pkg::ODW-1:0] o_m_tdata;
    logic [1:0]              o_m_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;

    intersect_sb sb;

    circle_line_intersection u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // no gap half the time, otherwise mostly short gaps and some long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One query transfer; data changes on the falling edge, valid drops only in a gap
    task automatic send_query(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                              logic signed [CB-1:0] r, logic signed [CB-1:0] sl,
                              logic signed [CB-1:0] ic);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tdata  <= {{(IDW-5*CB){1'b0}}, ic, sl, r, cy, cx};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_query(i_s_tdata);
        @(negedge i_clk);
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return CB'($urandom_range(0, 40) - 20);
        if (r < 7) return CB'($urandom_range(0, 400) - 200);
        return CB'($urandom);
    endfunction

    // Results sampled at the rising edge, tready toggled on falling edge
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_m_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    initial begin
        logic signed [CB-1:0] cx, cy, r, sl, ic;
        int w;
        sb = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad radius, tangent, two points, miss, extremes
        send_query(0, 0, 0, 0, 0);
        send_query(5, 5, -2048, 3, 3);
        send_query(0, 0, -1, 0, 0);
        send_query(0, 0, 5, 0, 5);         // tangent at top
        send_query(0, 0, 5, 0, -5);        // tangent at bottom
        send_query(0, 0, 5, 0, 0);         // horizontal chord
        send_query(0, 0, 5, 0, 6);         // miss
        send_query(0, 0, 1, 1, 0);         // irrational roots
        send_query(3, -4, 7, -2, 1);
        send_query(-3, 4, 7, 2, -1);
        send_query(0, 0, 2047, 2047, 2047);
        send_query(0, 0, 2047, -2048, -2048);
        send_query(-2048, -2048, 2047, 2047, 2047);
        send_query(2047, 2047, 2047, -2048, -2048);
        send_query(-2048, 2047, 2047, 0, -2048);
        send_query(2047, -2048, 2047, -1, 0);
        send_query(-1, -1, 1, -1, -1);
        send_query(1000, -1000, 1500, 1, 0);
        send_query(0, 0, 5, 1, 0);
        send_query(0, 0, 1, 0, 1);
        send_query(0, 0, 1, -2048, 0);

        for (int n = 0; n < 550; n++) begin
            cx = rnd_coord();
            cy = rnd_coord();
            sl = rnd_coord();
            w  = $urandom_range(0, 9);
            r  = (w == 0) ? CB'($urandom) : (w < 5) ? CB'($urandom_range(1, 60))
                                                      : CB'($urandom_range(1, 2047));
            // steer the line near the center so most queries hit
            if ($urandom_range(0, 2) != 0) begin
                longint base;
                base = longint'(cy) - longint'(sl) * longint'(cx)
                       + longint'(int'($urandom_range(0, 20))) - 10;
                ic = (base > 2047 || base < -2048) ? rnd_coord() : CB'(base);
            end else begin
                ic = rnd_coord();
            end
            send_query(cx, cy, r, sl, ic);
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/cli_pkg.sv
src/circle_line_intersection.sv
src/cli_checker.sv
tb/sv/tb.sv
